/* rtl/swfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_pkg
// Shared types and register codes of the sync word frame extractor.
// ----------------------------------------------------------------------------
package swfe_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SYNC_PATTERN = 2'd1;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

  localparam int unsigned BURST_BYTES = 8;

  // One burst of output bytes produced by one input byte
  typedef struct packed {
    logic [8*BURST_BYTES-1:0] data;   // byte 0 in low bits goes out first
    logic [3:0]               cnt;    // number of bytes, 1 to 8
    logic                     last;   // final byte of the burst ends the message
  } desc_t;

endpackage

/* rtl/swfe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_front
// Holds the configuration, hunts for the sync word and tracks the message
// count; turns each accepted byte into zero or one output burst.
// ----------------------------------------------------------------------------
module swfe_front #(
  parameter int SYNC_CAP  = 8,
  parameter int FRAME_MAX = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  output logic                 emit_o,
  output swfe_pkg::desc_t      desc_o
);
  import swfe_pkg::*;

  localparam int CW  = $clog2(SYNC_CAP + 1);
  localparam int BLW = $clog2(FRAME_MAX + 1);

  logic [3:0]     sync_length_q;
  logic [63:0]    sync_pattern_q;
  logic [12:0]    frame_length_q;

  logic [7:0]     win_q [SYNC_CAP];
  logic [7:0]     win_d [SYNC_CAP];
  logic [CW-1:0]  fill_q, fill_d;
  logic           in_frame_q, in_frame_d;
  logic [BLW-1:0] left_q, left_d;

  logic [CW-1:0]  sync_len;
  logic [BLW-1:0] flen;
  logic [31:0]    flen_w;

  // Effective lengths after saturation
  always_comb begin
    flen_w = {19'd0, frame_length_q};
    if (flen_w == 32'd0) begin
      flen_w = 32'd1;
    end else if (flen_w > 32'(FRAME_MAX)) begin
      flen_w = 32'(FRAME_MAX);
    end
    flen = flen_w[BLW-1:0];
    if ({28'd0, sync_length_q} > 32'(SYNC_CAP)) begin
      sync_len = CW'(SYNC_CAP);
    end else begin
      sync_len = sync_length_q[CW-1:0];
    end
  end

  // Window is kept newest first; fill counts valid bytes since the last clear
  always_comb begin
    logic [CW-1:0]  nf;
    logic [BLW-1:0] bl_dec;
    logic [7:0]     sel;
    logic           match;

    win_d      = win_q;
    fill_d     = fill_q;
    in_frame_d = in_frame_q;
    left_d     = left_q;
    emit_o     = 1'b0;
    desc_o     = '0;
    nf         = '0;
    sel        = '0;
    match      = 1'b0;
    bl_dec     = (left_q != '0) ? left_q - 1'b1 : '0;

    if (in_frame_q) begin
      emit_o            = 1'b1;
      desc_o.data[7:0]  = data_byte_i;
      desc_o.cnt        = 4'd1;
      left_d            = bl_dec;
      if (bl_dec == '0) begin
        desc_o.last = 1'b1;
        in_frame_d  = 1'b0;
        fill_d      = '0;
      end
    end else if (sync_len == '0) begin
      emit_o           = 1'b1;
      desc_o.data[7:0] = data_byte_i;
      desc_o.cnt       = 4'd1;
      if (flen == BLW'(1)) begin
        desc_o.last = 1'b1;
      end else begin
        in_frame_d = 1'b1;
        left_d     = flen - 1'b1;
        fill_d     = '0;
      end
    end else begin
      win_d[0] = data_byte_i;
      for (int k = 1; k < SYNC_CAP; k++) begin
        win_d[k] = win_q[k-1];
      end
      nf = (fill_q >= CW'(SYNC_CAP)) ? CW'(SYNC_CAP) : fill_q + 1'b1;

      match = (nf >= sync_len);
      for (int i = 0; i < SYNC_CAP; i++) begin
        if (CW'(i) < sync_len) begin
          sel = '0;
          for (int j = 0; j < SYNC_CAP; j++) begin
            if (CW'(j) == sync_len - CW'(i) - 1'b1) begin
              sel = win_d[j];
            end
          end
          if (sel != sync_pattern_q[8*i +: 8]) begin
            match = 1'b0;
          end
        end
      end

      if (match) begin
        // emit the sync word itself, cut short by a short message
        emit_o      = 1'b1;
        desc_o.data = sync_pattern_q;
        fill_d      = '0;
        if (flen <= BLW'(sync_len)) begin
          desc_o.cnt  = flen[3:0];
          desc_o.last = 1'b1;
        end else begin
          desc_o.cnt = 4'(sync_len);
          in_frame_d = 1'b1;
          left_d     = flen - BLW'(sync_len);
        end
      end else begin
        fill_d = nf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_length_q  <= '0;
      sync_pattern_q <= '0;
      frame_length_q <= 13'd1;
      for (int k = 0; k < SYNC_CAP; k++) begin
        win_q[k] <= '0;
      end
      fill_q         <= '0;
      in_frame_q     <= 1'b0;
      left_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SYNC_LENGTH:  sync_length_q  <= cfg_data_i[3:0];
          REG_SYNC_PATTERN: sync_pattern_q <= cfg_data_i;
          REG_FRAME_LENGTH: frame_length_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        win_q      <= win_d;
        fill_q     <= fill_d;
        in_frame_q <= in_frame_d;
        left_q     <= left_d;
      end
    end
  end

endmodule

/* rtl/swfe_desc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_desc_fifo
// Short queue of output bursts between the hunting front and the byte
// serializer.
// ----------------------------------------------------------------------------
module swfe_desc_fifo #(
  parameter int DEPTH = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  swfe_pkg::desc_t wdata_i,
  input  logic            pop_i,
  output swfe_pkg::desc_t head_o,
  output logic            nonempty_o,
  output logic            full_o
);
  import swfe_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  desc_t         mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == NW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/swfe_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_serializer
// Walks the head burst one byte per transaction and retires it after its
// final byte.
// ----------------------------------------------------------------------------
module swfe_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swfe_pkg::desc_t head_i,
  input  logic            head_valid_i,
  output logic            head_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o
);
  import swfe_pkg::*;

  logic [2:0] idx_q;
  logic       last_byte;
  logic       take;

  assign empty_o     = !head_valid_i;
  assign take        = pop_i && head_valid_i;
  assign last_byte   = ({1'b0, idx_q} + 4'd1 == head_i.cnt);
  assign out_byte_o  = head_i.data[{idx_q, 3'b000} +: 8];
  assign frame_end_o = head_i.last && last_byte;
  assign head_pop_o  = take && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last_byte ? '0 : idx_q + 1'b1;
    end
  end

endmodule

/* rtl/sync_word_frame_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_frame_extractor
// Byte stream framer: hunts for a sync word, then passes fixed-length
// messages and flags their last byte.
// ----------------------------------------------------------------------------
// A byte queued at an edge into an empty queue is on the result ports after it.
// Throughput: one byte in per cycle unless full; one out per cycle while popped.
// A sync match queues a burst of up to 8 bytes; the burst queue holds
// min(SYNC_MAX,8)+2 bursts and full rises only when it is used up.
// Reset: asynchronous, active low; clears the hunt state, the queue and the
// registers (sync_length 0, sync_pattern 0, frame_length 1).
module sync_word_frame_extractor #(
  parameter int SYNC_MAX  = 8,
  parameter int FRAME_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);
  import swfe_pkg::*;

  localparam int SYNC_CAP = (SYNC_MAX < 8) ? SYNC_MAX : 8;
  localparam int QDEPTH   = SYNC_CAP + 2;

  logic  accept;
  logic  emit;
  desc_t desc;
  desc_t head;
  logic  head_valid;
  logic  head_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  swfe_front #(
    .SYNC_CAP  (SYNC_CAP),
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .emit_o      (emit),
    .desc_o      (desc)
  );

  swfe_desc_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && emit),
    .wdata_i    (desc),
    .pop_i      (head_pop),
    .head_o     (head),
    .nonempty_o (head_valid),
    .full_o     (full)
  );

  swfe_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

/* rtl/swfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfe_checker
// Port-level checks of the sync word frame extractor.
// ----------------------------------------------------------------------------
module swfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       frame_end_o
);

  // Queue is empty and open while held in reset
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("outputs not idle during reset");

  // A result never appears without an accepted transaction behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && !(push && !full)) |=> empty)
    else $error("result appeared without input");

  // A waiting result stays until taken
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(out_byte_o) && $stable(frame_end_o)))
    else $error("waiting result changed");

endmodule

bind sync_word_frame_extractor swfe_checker u_swfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte_o  (out_byte_o),
  .frame_end_o (frame_end_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync word frame extractor. A table of directed
// bytes and register writes runs first, then random phases of framed streams,
// noise and broken sync words under random settings, then the opening bytes
// of a message with an oversized frame length. Every byte taken from the
// input queue goes through a local framer model; every byte popped from the
// result queue is checked against it, or against the row for typed table rows.
// ----------------------------------------------------------------------------
module tb_top;
  import swfe_pkg::*;

  localparam int          HALF_PERIOD  = 2;
  localparam int unsigned SYNC_DEPTH   = 8;
  localparam int unsigned FRAME_CAP    = 4096;
  localparam int          RESET_CYCLES = 9;
  localparam int          DRAIN_CYCLES = 4;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          RANDOM_BYTES = 200;
  localparam int          LONG_BYTES   = 16;
  localparam int          LIMIT_NS     = 4_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

  typedef enum bit {ROW_BYTE, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [63:0] val;
    logic [7:0]  din;
    bit          typed;   // expected output given in the row
    logic [7:0]  t_byte;
    bit          t_end;
  } row_t;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_QUARTER, POP_MOSTLY} pop_mode_e;

  // Directed table: extremes, zero frame length, empty sync word, short
  // message, saturated sync length and an 8-byte sync burst.
  localparam row_t DIR_TAB [33] = '{
    '{ROW_BYTE, '0, 64'd0, 8'h00, 1'b1, 8'h00, 1'b1},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b1, 8'hFF, 1'b1},
    '{ROW_REG, REG_FRAME_LENGTH, 64'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hA5, 1'b1, 8'hA5, 1'b1},
    '{ROW_REG, REG_FRAME_LENGTH, 64'd3, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h01, 1'b1, 8'h01, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h02, 1'b1, 8'h02, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h03, 1'b1, 8'h03, 1'b1},
    '{ROW_REG, REG_SYNC_PATTERN, 64'hBBAA, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_SYNC_LENGTH, 64'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_FRAME_LENGTH, 64'd4, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h11, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hAA, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hBB, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h05, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'h06, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_SYNC_PATTERN, 64'hC3B2A1, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_SYNC_LENGTH, 64'd3, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_FRAME_LENGTH, 64'd2, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hA1, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hB2, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hC3, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_SYNC_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_SYNC_LENGTH, 64'd15, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_REG, REG_FRAME_LENGTH, 64'd8, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, '0, 64'd0, 8'hFF, 1'b0, 8'h00, 1'b0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;

  // Framer model state and registers
  logic [3:0]  m_sync_len;
  logic [63:0] m_pattern;
  logic [12:0] m_frame_len;
  logic [7:0]  win [SYNC_DEPTH];
  int unsigned win_fill;
  bit          in_msg;
  int unsigned msg_left;
  out_t        step_bytes[$];

  out_t        pending_bytes[$];
  out_t        want;
  int          mismatches   = 0;
  int          bytes_sent   = 0;
  int          burst_left   = 0;
  pop_mode_e   pop_mode     = POP_ALWAYS;
  int          pop_left     = 0;
  int unsigned pop_tick     = 0;

  sync_word_frame_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int unsigned eff_sync_len();
    return (m_sync_len > SYNC_DEPTH) ? SYNC_DEPTH : int'(m_sync_len);
  endfunction

  function automatic logic [7:0] sync_byte(int unsigned i);
    return m_pattern[8*i +: 8];
  endfunction

  function automatic void clear_framer();
    m_sync_len  = '0;
    m_pattern   = '0;
    m_frame_len = 13'd1;
    foreach (win[i]) win[i] = '0;
    win_fill = 0;
    in_msg   = 1'b0;
    msg_left = 0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      REG_SYNC_LENGTH:  m_sync_len  = val[3:0];
      REG_SYNC_PATTERN: m_pattern   = val;
      REG_FRAME_LENGTH: m_frame_len = val[12:0];
      default: ;
    endcase
  endfunction

  // Advance the framer by one input byte; the bytes it releases land in step_bytes.
  function automatic void frame_byte(logic [7:0] b);
    int unsigned sl;
    int unsigned flen;
    int unsigned start;
    bit          hit;
    step_bytes.delete();
    if (in_msg) begin
      if (msg_left > 0) msg_left--;
      if (msg_left == 0) begin
        in_msg   = 1'b0;
        win_fill = 0;
        step_bytes.push_back(out_t'{b, 1'b1});
      end else begin
        step_bytes.push_back(out_t'{b, 1'b0});
      end
      return;
    end
    sl   = eff_sync_len();
    flen = (m_frame_len == 0) ? 1 : ((m_frame_len > FRAME_CAP) ? FRAME_CAP : m_frame_len);
    if (sl == 0) begin
      if (flen <= 1) begin
        step_bytes.push_back(out_t'{b, 1'b1});
      end else begin
        step_bytes.push_back(out_t'{b, 1'b0});
        in_msg   = 1'b1;
        msg_left = flen - 1;
        win_fill = 0;
      end
      return;
    end
    // slide the hunting window
    if (win_fill >= SYNC_DEPTH) begin
      for (int i = 0; i < SYNC_DEPTH - 1; i++) win[i] = win[i+1];
      win_fill = SYNC_DEPTH - 1;
    end
    win[win_fill] = b;
    win_fill++;
    if (win_fill < sl) return;
    start = win_fill - sl;
    hit   = 1'b1;
    for (int i = 0; i < sl; i++) begin
      if (win[start+i] != sync_byte(i)) hit = 1'b0;
    end
    if (!hit) return;
    for (int i = 0; i < sl && i < flen; i++) begin
      step_bytes.push_back(out_t'{win[start+i], (i + 1 == flen)});
    end
    win_fill = 0;
    foreach (win[i]) win[i] = '0;
    if (flen > sl) begin
      in_msg   = 1'b1;
      msg_left = flen - sl;
    end
  endfunction

  // Write one register once nothing is outstanding.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Push one byte, with random gaps between bursts.
  task automatic push_byte(logic [7:0] b, bit typed = 1'b0, out_t t = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    frame_byte(b);
    if (typed) pending_bytes.push_back(t);
    else foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
  endtask

  // One phase: new settings, then framed streams mixed with noise and broken sync words.
  task automatic random_phase();
    logic [3:0]  sl;
    logic [63:0] pat;
    logic [12:0] fl;
    bit          wrote;
    int          target;
    int          base;
    int unsigned efs;
    int unsigned k;
    int unsigned bad;
    case ($urandom_range(0, 7))
      0:       sl = 4'd0;
      1:       sl = 4'd8;
      2:       sl = 4'd15;
      3:       sl = 4'($urandom_range(9, 14));
      default: sl = 4'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       pat = '0;
      1:       pat = '1;
      default: pat = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 7))
      0:       fl = 13'd0;
      1:       fl = 13'd1;
      default: fl = 13'($urandom_range(2, 24));
    endcase
    wrote = 1'b0;
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_SYNC_PATTERN, pat);
      wrote = 1'b1;
    end
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_SYNC_LENGTH, {60'd0, sl});
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(0, 3) != 0) write_reg(REG_FRAME_LENGTH, {51'd0, fl});
    efs    = eff_sync_len();
    target = $urandom_range(15, 45);
    base   = bytes_sent;
    while (bytes_sent - base < target) begin
      k = $urandom_range(0, 19);
      if (k < 14) begin
        for (int i = 0; i < efs; i++) push_byte(sync_byte(i));
        repeat ($urandom_range(0, int'(m_frame_len) + 2)) push_byte(8'($urandom_range(0, 255)));
      end else if (k < 17 || efs == 0) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // corrupt one byte of a sync prefix
        k   = $urandom_range(1, efs);
        bad = $urandom_range(0, k - 1);
        for (int i = 0; i < k; i++) begin
          if (i == bad) push_byte(sync_byte(i) ^ (8'd1 << $urandom_range(0, 7)));
          else push_byte(sync_byte(i));
        end
      end
    end
  endtask

  // Result side: check each popped byte against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h end %b",
                 $time, out_byte_o, frame_end_o);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, out_byte_o);
          mismatches++;
        end
        if (frame_end_o !== want.last) begin
          $display("%0t: frame_end mismatch: expected %b, actual %b",
                   $time, want.last, frame_end_o);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall pattern: switch modes every so often
  always @(negedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode = pop_mode_e'($urandom_range(0, 3));
      pop_left = $urandom_range(16, 160);
    end
    pop_left--;
    pop_tick++;
    case (pop_mode)
      POP_ALWAYS:  pop <= 1'b1;
      POP_COIN:    pop <= 1'($urandom_range(0, 1));
      POP_QUARTER: pop <= (pop_tick % 4 == 0);
      default:     pop <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    #(LIMIT_NS);
    $display("[sync_word_frame_extractor] ERROR");
    $finish;
  end

  initial begin
    int base;
    rst_ni = 1'b0;
    clear_framer();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_REG) write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
      else push_byte(DIR_TAB[i].din, DIR_TAB[i].typed,
                     out_t'{DIR_TAB[i].t_byte, DIR_TAB[i].t_end});
    end

    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) random_phase();

    // Frame length above the cap: open a message and stream part of it
    write_reg(REG_SYNC_LENGTH, 64'd1);
    write_reg(REG_SYNC_PATTERN, {$urandom, $urandom});
    write_reg(REG_FRAME_LENGTH, 64'h1FFF);
    push_byte(sync_byte(0));
    repeat (LONG_BYTES) push_byte(8'($urandom_range(0, 255)));

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[sync_word_frame_extractor] OK");
    end else begin
      $display("[sync_word_frame_extractor] ERROR");
    end
    $finish;
  end

endmodule
